FILE: design/tps_pkg.sv
// Shared types and constants for the timer prescaler select block.
// Used by the controller, the datapath and the top level; no dependencies.
package tps_pkg;

  localparam int CYCLES_W = 32;
  localparam int LIMIT_W  = 17;
  localparam int DIV_W    = 16;
  localparam int CMP_W    = 16;
  localparam int IDX_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_CNT_W = 5;

  localparam int TABLE_REGS       = 5;
  localparam int MAX_DIVISORS_DEF = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 17'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd65536;

  // reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RST_LIMIT = 17'd256;
  localparam logic [IDX_W-1:0]   RST_COUNT = 3'd5;
  localparam logic [DIV_W-1:0]   RST_DIV0  = 16'd1;
  localparam logic [DIV_W-1:0]   RST_DIV1  = 16'd8;
  localparam logic [DIV_W-1:0]   RST_DIV2  = 16'd64;
  localparam logic [DIV_W-1:0]   RST_DIV3  = 16'd256;
  localparam logic [DIV_W-1:0]   RST_DIV4  = 16'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIV2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIV3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIV4  = 3'd6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch request, restart table scan
    logic prod;       // form limit * divisor for current entry
    logic next;       // advance to next table entry
    logic div_start;  // entry fits, prepare the divider
    logic div_step;   // one restoring divide step
    logic finish;     // form result and strobe it out
  } tps_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic fit;        // request below limit * divisor
    logic last;       // current entry is the last valid one
    logic div_last;   // final divide step in progress
  } tps_stat_t;

endpackage

FILE: design/tps_ctrl.sv
// Controller state machine of the timer prescaler select block.
// Sequences table scan, divide and result; depends on tps_pkg.
module tps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tps_pkg::tps_stat_t stat,
  output tps_pkg::tps_cmd_t  cmd
);
  import tps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PROD = 5'b00010,
    S_TEST = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.fit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (stat.last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.next  = 1'b1;
          state_nxt = S_PROD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/tps_datapath.sv
// Datapath of the timer prescaler select block: configuration registers,
// limit product, bit-serial divider and result registers; depends on tps_pkg.
module tps_datapath #(
  parameter int MAX_DIVISORS = tps_pkg::MAX_DIVISORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tps_pkg::CYCLES_W-1:0]     in_requested_cycles,
  input  tps_pkg::tps_cmd_t                cmd,
  output tps_pkg::tps_stat_t               stat,
  output logic                             out_valid,
  output logic [tps_pkg::CMP_W-1:0]        out_compare_value,
  output logic [tps_pkg::DIV_W-1:0]        out_chosen_divisor,
  output logic [tps_pkg::IDX_W-1:0]        out_chosen_index,
  output logic [tps_pkg::CYCLES_W-1:0]     out_achieved_cycles,
  output logic                             out_clamped
);
  import tps_pkg::*;

  localparam int CAP = (MAX_DIVISORS < TABLE_REGS) ? MAX_DIVISORS : TABLE_REGS;
  localparam logic [IDX_W-1:0] CAP_N = IDX_W'(CAP);
  localparam int PROD_W = LIMIT_W + DIV_W;

  // configuration registers
  logic [LIMIT_W-1:0] limit_r;
  logic [IDX_W-1:0]   count_r;
  logic [DIV_W-1:0]   div_tab_r [TABLE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= RST_LIMIT;
      count_r      <= RST_COUNT;
      div_tab_r[0] <= RST_DIV0;
      div_tab_r[1] <= RST_DIV1;
      div_tab_r[2] <= RST_DIV2;
      div_tab_r[3] <= RST_DIV3;
      div_tab_r[4] <= RST_DIV4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT: limit_r      <= cfg_data[LIMIT_W-1:0];
        REG_COUNT: count_r      <= cfg_data[IDX_W-1:0];
        REG_DIV0:  div_tab_r[0] <= cfg_data[DIV_W-1:0];
        REG_DIV1:  div_tab_r[1] <= cfg_data[DIV_W-1:0];
        REG_DIV2:  div_tab_r[2] <= cfg_data[DIV_W-1:0];
        REG_DIV3:  div_tab_r[3] <= cfg_data[DIV_W-1:0];
        REG_DIV4:  div_tab_r[4] <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limit and count
  logic [LIMIT_W-1:0] lim_eff;
  logic [IDX_W-1:0]   cnt_eff;

  always_comb begin
    if (limit_r < LIMIT_MIN) begin
      lim_eff = LIMIT_MIN;
    end else if (limit_r > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = limit_r;
    end
    if (count_r == '0) begin
      cnt_eff = IDX_W'(1);
    end else if (count_r > CAP_N) begin
      cnt_eff = CAP_N;
    end else begin
      cnt_eff = count_r;
    end
  end

  // working registers
  logic [CYCLES_W-1:0]  q_r;       // request, then quotient
  logic [DIV_W-1:0]     rem_r;
  logic [IDX_W-1:0]     idx_r;
  logic [PROD_W-1:0]    prod_r;
  logic [DIV_CNT_W-1:0] bit_cnt_r;
  logic                 clamp_r;

  logic [DIV_W-1:0] div_cur;

  always_comb begin
    case (idx_r)
      3'd0:    div_cur = div_tab_r[0];
      3'd1:    div_cur = div_tab_r[1];
      3'd2:    div_cur = div_tab_r[2];
      3'd3:    div_cur = div_tab_r[3];
      3'd4:    div_cur = div_tab_r[4];
      default: div_cur = '0;
    endcase
  end

  // restoring divide step
  logic [DIV_W:0] trial;
  logic           take;
  logic [DIV_W:0] trial_diff;

  assign trial      = {rem_r, q_r[CYCLES_W-1]};
  assign take       = (trial >= {1'b0, div_cur});
  assign trial_diff = trial - {1'b0, div_cur};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r     <= in_requested_cycles;
      idx_r   <= '0;
      clamp_r <= 1'b1;
    end
    if (cmd.prod) begin
      prod_r <= PROD_W'(lim_eff) * PROD_W'(div_cur);
    end
    if (cmd.next) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      bit_cnt_r <= '0;
      clamp_r   <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r     <= take ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
      q_r       <= {q_r[CYCLES_W-2:0], take};
      bit_cnt_r <= bit_cnt_r + DIV_CNT_W'(1);
    end
  end

  assign stat.fit      = ({1'b0, q_r} < prod_r);
  assign stat.last     = (idx_r == (cnt_eff - IDX_W'(1)));
  assign stat.div_last = (bit_cnt_r == {DIV_CNT_W{1'b1}});

  // result
  logic [CMP_W-1:0] cmp_sel;
  logic [LIMIT_W-1:0] lim_m1;

  assign lim_m1  = lim_eff - LIMIT_W'(1);
  assign cmp_sel = clamp_r ? lim_m1[CMP_W-1:0] : q_r[CMP_W-1:0];

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_compare_value   <= cmp_sel;
      out_chosen_divisor  <= div_cur;
      out_chosen_index    <= idx_r;
      out_achieved_cycles <= CYCLES_W'(cmp_sel) * CYCLES_W'(div_cur);
      out_clamped         <= clamp_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/timer_prescaler_select_core.sv
// Timer prescaler select, top level: controller plus datapath.
// Depends on tps_pkg, tps_ctrl and tps_datapath.
//
// Pulse start while busy is low to transfer a requested period. The block
// scans the divisor table in order, forming the limit product and then
// comparing for each entry, runs a bit-serial divide of the 32-bit request
// when an entry fits, and puts the result out for exactly one cycle with
// out_valid high; the receiver cannot stall it, so it must take the
// transfer in that cycle. busy is low again in the strobe cycle, so the
// next start may come then. Configuration writes take effect at once and
// belong only to idle periods.
module timer_prescaler_select_core #(
  parameter int MAX_DIVISORS = tps_pkg::MAX_DIVISORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tps_pkg::CYCLES_W-1:0]   in_requested_cycles,
  input  logic                           cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [tps_pkg::CMP_W-1:0]      out_compare_value,
  output logic [tps_pkg::DIV_W-1:0]      out_chosen_divisor,
  output logic [tps_pkg::IDX_W-1:0]      out_chosen_index,
  output logic [tps_pkg::CYCLES_W-1:0]   out_achieved_cycles,
  output logic                           out_clamped
);
  import tps_pkg::*;

  tps_cmd_t  cmd;
  tps_stat_t stat;

  tps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tps_datapath #(
    .MAX_DIVISORS (MAX_DIVISORS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_requested_cycles (in_requested_cycles),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_compare_value   (out_compare_value),
    .out_chosen_divisor  (out_chosen_divisor),
    .out_chosen_index    (out_chosen_index),
    .out_achieved_cycles (out_achieved_cycles),
    .out_clamped         (out_clamped)
  );

endmodule

FILE: tb/prescaler_checker.sv
// Checker for timer_prescaler_select_core: watches the request, result and
// register write ports, predicts each result and compares it field by field.
// Depends on tps_pkg only.
module prescaler_checker #(
  parameter int MAX_DIVISORS = tps_pkg::MAX_DIVISORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [tps_pkg::CYCLES_W-1:0]   in_requested_cycles,
  input  logic                           cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_valid,
  input  logic [tps_pkg::CMP_W-1:0]      out_compare_value,
  input  logic [tps_pkg::DIV_W-1:0]      out_chosen_divisor,
  input  logic [tps_pkg::IDX_W-1:0]      out_chosen_index,
  input  logic [tps_pkg::CYCLES_W-1:0]   out_achieved_cycles,
  input  logic                           out_clamped,
  output int                             fail_count,
  output int                             pending
);
  import tps_pkg::*;

  typedef struct packed {
    logic [CMP_W-1:0]    compare;
    logic [DIV_W-1:0]    divisor;
    logic [IDX_W-1:0]    index;
    logic [CYCLES_W-1:0] achieved;
    logic                clamped;
  } prescaler_choice_t;

  logic [LIMIT_W-1:0] limit_reg;
  logic [IDX_W-1:0]   count_reg;
  logic [DIV_W-1:0]   div_table [TABLE_REGS];
  prescaler_choice_t  expected_choices [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string field, input logic [CYCLES_W-1:0] got,
                                 input logic [CYCLES_W-1:0] want);
    $display("%0t prescaler_checker: %s got %0d, wanted %0d", $time, field, got, want);
    fail_count++;
  endtask

  function automatic prescaler_choice_t choose_prescaler(input logic [CYCLES_W-1:0] cycles);
    logic [LIMIT_W-1:0] lim;
    logic [63:0]        span;
    int                 cnt;
    int                 cap;
    int                 i;
    logic               found;
    prescaler_choice_t  r;
    lim = limit_reg;
    if (lim < LIMIT_MIN) begin
      lim = LIMIT_MIN;
    end else if (lim > LIMIT_MAX) begin
      lim = LIMIT_MAX;
    end
    cap = (MAX_DIVISORS < TABLE_REGS) ? MAX_DIVISORS : TABLE_REGS;
    cnt = (count_reg == '0) ? 1 : int'(count_reg);
    if (cnt > cap) cnt = cap;
    found = 1'b0;
    r = '0;
    for (i = 0; i < cnt; i++) begin
      // wide product, a zero divisor never fits
      span = 64'(lim) * 64'(div_table[i]);
      if (!found && 64'(cycles) < span) begin
        r.compare = CMP_W'(cycles / 32'(div_table[i]));
        r.divisor = div_table[i];
        r.index   = IDX_W'(i);
        found     = 1'b1;
      end
    end
    if (!found) begin
      r.index   = IDX_W'(cnt - 1);
      r.divisor = div_table[cnt - 1];
      r.compare = CMP_W'(lim - 1'b1);
      r.clamped = 1'b1;
    end
    r.achieved = 32'(r.compare) * 32'(r.divisor);
    return r;
  endfunction

  always @(posedge clk) begin
    prescaler_choice_t want;
    if (!rst_n) begin
      limit_reg    = RST_LIMIT;
      count_reg    = RST_COUNT;
      div_table[0] = RST_DIV0;
      div_table[1] = RST_DIV1;
      div_table[2] = RST_DIV2;
      div_table[3] = RST_DIV3;
      div_table[4] = RST_DIV4;
      expected_choices.delete();
    end else begin
      if (out_valid) begin
        if (expected_choices.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding", CYCLES_W'(1),
                          CYCLES_W'(0));
        end else begin
          want = expected_choices.pop_front();
          if (out_compare_value !== want.compare)
            report_mismatch("compare_value", CYCLES_W'(out_compare_value),
                            CYCLES_W'(want.compare));
          if (out_chosen_divisor !== want.divisor)
            report_mismatch("chosen_divisor", CYCLES_W'(out_chosen_divisor),
                            CYCLES_W'(want.divisor));
          if (out_chosen_index !== want.index)
            report_mismatch("chosen_index", CYCLES_W'(out_chosen_index),
                            CYCLES_W'(want.index));
          if (out_achieved_cycles !== want.achieved)
            report_mismatch("achieved_cycles", out_achieved_cycles, want.achieved);
          if (out_clamped !== want.clamped)
            report_mismatch("clamped", CYCLES_W'(out_clamped), CYCLES_W'(want.clamped));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LIMIT: limit_reg    = cfg_data;
          REG_COUNT: count_reg    = cfg_data[IDX_W-1:0];
          REG_DIV0:  div_table[0] = cfg_data[DIV_W-1:0];
          REG_DIV1:  div_table[1] = cfg_data[DIV_W-1:0];
          REG_DIV2:  div_table[2] = cfg_data[DIV_W-1:0];
          REG_DIV3:  div_table[3] = cfg_data[DIV_W-1:0];
          REG_DIV4:  div_table[4] = cfg_data[DIV_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_choices.push_back(choose_prescaler(in_requested_cycles));
      end
    end
    pending = expected_choices.size();
  end

endmodule

FILE: tb/tb_timer_prescaler_select_core.sv
// Top of the timer_prescaler_select_core testbench: clock, reset, request
// and register stimulus, and the verdict. Depends on tps_pkg, the block and
// prescaler_checker.
module tb_timer_prescaler_select_core;
  import tps_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RANDOM_ITEMS = 1000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CYCLES_W-1:0]   in_requested_cycles;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic [CMP_W-1:0]      out_compare_value;
  logic [DIV_W-1:0]      out_chosen_divisor;
  logic [IDX_W-1:0]      out_chosen_index;
  logic [CYCLES_W-1:0]   out_achieved_cycles;
  logic                  out_clamped;
  int                    fail_count;
  int                    pending;

  // stimulus-side copy of the settings, used only to aim at fit boundaries
  logic [LIMIT_W-1:0]    cur_limit;
  logic [DIV_W-1:0]      cur_div [TABLE_REGS];
  bit                    no_gaps;

  always #HALF_PERIOD clk = ~clk;

  timer_prescaler_select_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_requested_cycles (in_requested_cycles),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_compare_value   (out_compare_value),
    .out_chosen_divisor  (out_chosen_divisor),
    .out_chosen_index    (out_chosen_index),
    .out_achieved_cycles (out_achieved_cycles),
    .out_clamped         (out_clamped)
  );

  prescaler_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_requested_cycles (in_requested_cycles),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_compare_value   (out_compare_value),
    .out_chosen_divisor  (out_chosen_divisor),
    .out_chosen_index    (out_chosen_index),
    .out_achieved_cycles (out_achieved_cycles),
    .out_clamped         (out_clamped),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // write enable stays high across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_table(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] cnt,
                            input logic [CFG_DATA_W-1:0] d0, input logic [CFG_DATA_W-1:0] d1,
                            input logic [CFG_DATA_W-1:0] d2, input logic [CFG_DATA_W-1:0] d3,
                            input logic [CFG_DATA_W-1:0] d4);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_COUNT, cnt);
    write_reg(REG_DIV0, d0);
    write_reg(REG_DIV1, d1);
    write_reg(REG_DIV2, d2);
    write_reg(REG_DIV3, d3);
    write_reg(REG_DIV4, d4);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we     <= 1'b0;
    cur_limit  = lim;
    cur_div[0] = d0[DIV_W-1:0];
    cur_div[1] = d1[DIV_W-1:0];
    cur_div[2] = d2[DIV_W-1:0];
    cur_div[3] = d3[DIV_W-1:0];
    cur_div[4] = d4[DIV_W-1:0];
  endtask

  // start stays high after a transfer, so a zero gap keeps requests back to back
  task automatic request_period(input logic [CYCLES_W-1:0] cycles);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start               <= 1'b1;
    in_requested_cycles <= cycles;
    do @(posedge clk); while (busy);
  endtask

  task automatic end_phase;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [CYCLES_W-1:0] pick_period();
    logic [LIMIT_W-1:0] lim;
    logic [63:0]        boundary;
    lim = cur_limit;
    if (lim < LIMIT_MIN) lim = LIMIT_MIN;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return $urandom_range(0, 1023);
      2: return $urandom() >> $urandom_range(0, 31);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: begin
        // just below, at and just above lim * divisor
        boundary = 64'(lim) * 64'(cur_div[$urandom_range(0, TABLE_REGS - 1)]);
        boundary = boundary + 64'($urandom_range(0, 3));
        boundary = (boundary >= 2) ? boundary - 2 : 64'd0;
        if (boundary > 64'hFFFF_FFFF) boundary = 64'hFFFF_FFFF;
        return boundary[CYCLES_W-1:0];
      end
    endcase
  endfunction

  task automatic random_setup;
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] cnt;
    logic [CFG_DATA_W-1:0] d [TABLE_REGS];
    int                    prev;
    int                    i;
    case ($urandom_range(0, 5))
      0:       lim = CFG_DATA_W'($urandom_range(0, 3));
      1:       lim = CFG_DATA_W'($urandom_range(65534, 131071));
      2:       lim = CFG_DATA_W'($urandom_range(0, 131071));
      default: lim = CFG_DATA_W'($urandom_range(4, 600));
    endcase
    // junk in the upper bits of the count write
    cnt = CFG_DATA_W'($urandom);
    cnt[IDX_W-1:0] = IDX_W'($urandom_range(0, 7));
    prev = 1;
    for (i = 0; i < TABLE_REGS; i++) begin
      case ($urandom_range(0, 9))
        0:       d[i] = '0;
        1:       d[i] = 17'd65535;
        2:       d[i] = CFG_DATA_W'($urandom);
        default: begin
          d[i] = CFG_DATA_W'($urandom_range(prev,
                                            (prev * 8 + 8 > 65535) ? 65535 : prev * 8 + 8));
          prev = int'(d[i]);
        end
      endcase
    end
    load_table(lim, cnt, d[0], d[1], d[2], d[3], d[4]);
  endtask

  initial begin
    logic [CYCLES_W-1:0] reset_periods [$];
    int                  sent;
    int                  burst;
    start               = 1'b0;
    in_requested_cycles = '0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    rst_n               = 1'b0;
    no_gaps             = 1'b0;
    cur_limit           = RST_LIMIT;
    cur_div[0]          = RST_DIV0;
    cur_div[1]          = RST_DIV1;
    cur_div[2]          = RST_DIV2;
    cur_div[3]          = RST_DIV3;
    cur_div[4]          = RST_DIV4;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset table: each entry's boundary, then clamping
    reset_periods = '{32'd0, 32'd1, 32'd255, 32'd256, 32'd2047, 32'd2048, 32'd16384,
                      32'd65535, 32'd65536, 32'd262143, 32'd262144, 32'hFFFF_FFFF};
    foreach (reset_periods[k]) request_period(reset_periods[k]);
    end_phase();

    // limit and count below range, lone zero divisor: always clamps, compare value one
    load_table(17'd0, 17'd0, 17'd0, 17'd5, 17'd6, 17'd7, 17'd8);
    request_period(32'd0);
    request_period(32'd1);
    request_period(32'hFFFF_FFFF);
    end_phase();

    // limit one, count above range, zero and largest divisors
    load_table(17'd1, 17'd7, 17'd0, 17'd3, 17'd65535, 17'd2, 17'd65535);
    request_period(32'd0);
    request_period(32'd5);
    request_period(32'd6);
    request_period(32'hFFFF_FFFF);
    end_phase();

    // limit above range, largest compare value and achieved period
    load_table(17'h1FFFF, 17'd5, 17'd1, 17'd2, 17'd4, 17'd8, 17'h1FFFF);
    request_period(32'd65535);
    request_period(32'd65536);
    request_period(32'hFFFE_FFFF);
    request_period(32'hFFFF_0000);
    request_period(32'hFFFF_FFFF);
    end_phase();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setup();
      no_gaps = ($urandom_range(0, 3) == 0);
      burst   = int'($urandom_range(20, 80));
      repeat (burst) request_period(pick_period());
      sent += burst;
      end_phase();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * 800_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: timer_prescaler_select_core.f
design/tps_pkg.sv
design/tps_ctrl.sv
design/tps_datapath.sv
design/timer_prescaler_select_core.sv
tb/prescaler_checker.sv
tb/tb_timer_prescaler_select_core.sv
